// ===== rtl/core/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and helpers of the word splitter
// Result record, per-item result bundle, character codes, counter helpers.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // Width of the line and column counters
    localparam int COUNT_BITS  = 16;
    // Width of the reported line and column fields
    localparam int FIELD_W     = 16;
    // Most results one input item can cause
    localparam int MAX_RESULTS = 3;
    // Result queue depth
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [FIELD_W-1:0]    FIELD_MAX = {FIELD_W{1'b1}};

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_EOI  = 2'd2;

    // Input function codes
    localparam logic FUNC_TEXT = 1'b0;
    localparam logic FUNC_EOI  = 1'b1;

    // Special characters
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Scanner mode
    typedef enum logic [1:0] {
        MODE_EXPECT  = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_COMMENT = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         out_char;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic               last;
    } t_result;

    // All results of one input item, slot 0 first
    typedef struct packed {
        logic [1:0]                   n;
        t_result [MAX_RESULTS-1:0]    res;
    } t_bundle;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C, 8'h00, 8'hFF};
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return c inside {8'h5B, 8'h5D, 8'h28, 8'h29, 8'h3C, 8'h3E,
                         8'h7B, 8'h7D, 8'h2C, 8'h2A, 8'h21, 8'h3D};
    endfunction

    // Saturating increment of a counter
    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    // Clamp a counter to the reported field width
    function automatic logic [FIELD_W-1:0] clamp_field(input logic [COUNT_BITS-1:0] v);
        logic [FIELD_W-1:0] r;
        if (COUNT_BITS > FIELD_W && v > COUNT_BITS'(FIELD_MAX)) begin
            r = FIELD_MAX;
        end else begin
            r = FIELD_W'(v);
        end
        return r;
    endfunction

    function automatic t_result make_result(
        input logic [1:0]            kind,
        input logic [7:0]            ch,
        input logic [COUNT_BITS-1:0] ln,
        input logic [COUNT_BITS-1:0] col
    );
        t_result r;
        r.kind     = kind;
        r.out_char = ch;
        r.line     = clamp_field(ln);
        r.column   = clamp_field(col);
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/word_splitter_with_positions.sv =====
// ----------------------------------------------------------------------------
// word_splitter_with_positions: word splitter with line and column tags
// Splits a byte stream into words and reports each word character, each
// word end and each end of input together with its position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one item per byte, i_func = 0 for a
//   text byte in i_char_value, i_func = 1 for end of input.
//   Output channel (o_valid / i_ready): one result per transfer; o_kind
//   tells word character, word end or end of input, o_last marks the last
//   result of an input item. An item causes zero to three results.
//   Timing: an accepted item is held in the input register; its results
//   are written to the eight-entry result queue once the queue has room
//   for them, and the queue offers them from there. One item per cycle is
//   taken while the queue has space for three more results; delivery is
//   one result per cycle while i_ready is high, set by the queue's single
//   read port.
//   Reset: synchronous, active low; the scanner returns to line 0, column
//   0, outside any word, and the queue empties. No clearing pass.
//   Stall: while i_ready is low results stay in the queue; once it holds
//   more than five results an item in the input register waits there, with o_ready low.
// ----------------------------------------------------------------------------
module word_splitter_with_positions (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [7:0]                  i_char_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_out_char,
    output logic [wsp_pkg::FIELD_W-1:0] o_line,
    output logic [wsp_pkg::FIELD_W-1:0] o_column,
    output logic                        o_last
);
    import wsp_pkg::*;

    logic       r_in_valid;
    logic       r_func;
    logic [7:0] r_char;
    logic       room;
    logic       consume;
    t_bundle    bundle;
    t_result    result;

    // Process the held item once the queue can take a full bundle
    assign consume = r_in_valid && room;
    assign o_ready = !r_in_valid || consume;

    // Input register: load on accept, drop once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func <= i_func;
            r_char <= i_char_value;
        end
    end

    wsp_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (consume),
        .i_func       (r_func),
        .i_char_value (r_char),
        .o_bundle     (bundle)
    );

    wsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (consume),
        .i_bundle (bundle),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_kind     = result.kind;
    assign o_out_char = result.out_char;
    assign o_line     = result.line;
    assign o_column   = result.column;
    assign o_last     = result.last;

endmodule

// ===== rtl/core/wsp_scan.sv =====
// ----------------------------------------------------------------------------
// wsp_scan: scanner state and per-item result logic
// Holds mode, quote flag and position counters; turns one item into a
// bundle of up to three results and advances state when the item is taken.
// ----------------------------------------------------------------------------
module wsp_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_func,
    input  logic [7:0]        i_char_value,
    output wsp_pkg::t_bundle  o_bundle
);
    import wsp_pkg::*;

    t_mode                 r_mode,      n_mode;
    logic                  r_quote,     n_quote;
    logic [COUNT_BITS-1:0] r_line,      n_line;
    logic [COUNT_BITS-1:0] r_col,       n_col;
    logic [COUNT_BITS-1:0] r_ws_line,   n_ws_line;
    logic [COUNT_BITS-1:0] r_ws_col,    n_ws_col;
    t_bundle               bundle;
    logic [1:0]            cnt;
    logic                  do_expect;
    logic                  separator;

    // Advance scanner state on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_EXPECT;
            r_quote   <= 1'b0;
            r_line    <= '0;
            r_col     <= '0;
            r_ws_line <= '0;
            r_ws_col  <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_quote   <= n_quote;
            r_line    <= n_line;
            r_col     <= n_col;
            r_ws_line <= n_ws_line;
            r_ws_col  <= n_ws_col;
        end
    end

    // Next state and results of the current item
    always_comb begin
        n_mode    = r_mode;
        n_quote   = r_quote;
        n_line    = r_line;
        n_col     = r_col;
        n_ws_line = r_ws_line;
        n_ws_col  = r_ws_col;
        bundle    = '0;
        cnt       = 2'd0;
        do_expect = 1'b0;
        separator = (i_char_value == CH_SEMI) || is_blank(i_char_value)
                    || is_single(i_char_value);

        if (i_func == FUNC_EOI) begin
            // Close an open word, report end, return to reset state
            if (r_mode == MODE_WORD) begin
                bundle.res[cnt] = make_result(KIND_END, 8'h00, r_ws_line, r_ws_col);
                cnt = cnt + 2'd1;
            end
            bundle.res[cnt] = make_result(KIND_EOI, 8'h00, r_line, r_col);
            cnt = cnt + 2'd1;
            n_mode    = MODE_EXPECT;
            n_quote   = 1'b0;
            n_line    = '0;
            n_col     = '0;
            n_ws_line = '0;
            n_ws_col  = '0;
        end else begin
            case (r_mode)
                MODE_WORD: begin
                    if (r_quote || i_char_value == CH_QUOTE || !separator) begin
                        // Echo a word character; a quote toggles quoting
                        if (i_char_value == CH_QUOTE) begin
                            n_quote = !r_quote;
                        end
                        bundle.res[cnt] = make_result(KIND_CHAR, i_char_value,
                                                      n_line, n_col);
                        cnt = cnt + 2'd1;
                        n_col = cnt_inc(n_col);
                    end else begin
                        // Separator ends the word, then scan as if no word open
                        bundle.res[cnt] = make_result(KIND_END, 8'h00,
                                                      r_ws_line, r_ws_col);
                        cnt = cnt + 2'd1;
                        n_mode = MODE_EXPECT;
                        do_expect = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (i_char_value == CH_NEWLINE) begin
                        n_line = cnt_inc(r_line);
                        n_col  = '0;
                        n_mode = MODE_EXPECT;
                    end else begin
                        n_col = cnt_inc(r_col);
                    end
                end
                default: begin
                    n_mode = MODE_EXPECT;
                    do_expect = 1'b1;
                end
            endcase

            if (do_expect) begin
                if (i_char_value == CH_SEMI) begin
                    n_col  = cnt_inc(n_col);
                    n_mode = MODE_COMMENT;
                end else if (is_blank(i_char_value)) begin
                    if (i_char_value == CH_NEWLINE) begin
                        n_line = cnt_inc(n_line);
                        n_col  = '0;
                    end else begin
                        n_col = cnt_inc(n_col);
                    end
                end else begin
                    // Start a new word here
                    n_ws_line = n_line;
                    n_ws_col  = n_col;
                    bundle.res[cnt] = make_result(KIND_CHAR, i_char_value,
                                                  n_line, n_col);
                    cnt = cnt + 2'd1;
                    n_col = cnt_inc(n_col);
                    if (i_char_value == CH_QUOTE) begin
                        n_quote = 1'b1;
                        n_mode  = MODE_WORD;
                    end else if (is_single(i_char_value)) begin
                        bundle.res[cnt] = make_result(KIND_END, 8'h00,
                                                      n_ws_line, n_ws_col);
                        cnt = cnt + 2'd1;
                        n_mode = MODE_EXPECT;
                    end else begin
                        n_mode = MODE_WORD;
                    end
                end
            end
        end

        // Flag the final result of this item
        if (cnt != 2'd0) begin
            bundle.res[cnt - 2'd1].last = 1'b1;
        end
        bundle.n = cnt;
    end

    assign o_bundle = bundle;

    // An end of input leaves the scanner in its reset state
    a_eoi_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_func == FUNC_EOI) |=>
            (r_mode == MODE_EXPECT && !r_quote && r_line == '0 && r_col == '0))
        else $error("scanner state not cleared after end of input");

    // A quote is only ever open inside a word
    a_quote_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quote |-> r_mode == MODE_WORD)
        else $error("quote open outside a word");

    // End of input always reports at least its end marker
    a_eoi_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_func == FUNC_EOI) |-> bundle.n != 2'd0)
        else $error("end of input without end marker");

endmodule

// ===== rtl/core/wsp_queue.sv =====
// ----------------------------------------------------------------------------
// wsp_queue: result queue
// Takes a bundle of up to three results in a single write and delivers them
// one per cycle over a valid/ready channel while i_ready is high.
// ----------------------------------------------------------------------------
module wsp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsp_pkg::t_bundle  i_bundle,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output wsp_pkg::t_result  o_result
);
    import wsp_pkg::*;

    localparam int CNT_W = QPTR_W + 1;
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - MAX_RESULTS);

    t_result              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr,    n_wr;
    logic [QPTR_W-1:0]    r_rd,    n_rd;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 pop;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= ROOM_LIMIT);
    assign o_result = r_mem[r_rd];

    // Advance pointers and fill count
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr    = r_wr + QPTR_W'(i_bundle.n);
            n_count = n_count + CNT_W'(i_bundle.n);
        end
        if (pop) begin
            n_rd    = r_rd + QPTR_W'(1);
            n_count = n_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the results of one item in consecutive slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (2'(k) < i_bundle.n) begin
                    r_mem[r_wr + QPTR_W'(k)] <= i_bundle.res[k];
                end
            end
        end
    end

    // Fill count never passes the depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // A bundle is written only with room for a full bundle
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("result bundle written without room");

    // Pointer distance agrees with the fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wr - r_rd) == QPTR_W'(r_count))
        else $error("queue pointers disagree with fill count");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for word_splitter_with_positions
// Feeds text bytes and end-of-input items through the valid/ready input
// channel and predicts every word character, word end and end marker with
// its line and column. Results are checked in order, field by field.
// Stimulus covers each separator kind, quotes, comments and end of input in
// every scanner mode. Random text is then run under several pacing phases
// on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import wsp_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
    } t_text_item;

    // DUT ports
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    logic               i_func       = FUNC_TEXT;
    logic [7:0]         i_char_value = 8'h00;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    logic [1:0]         o_kind;
    logic [7:0]         o_out_char;
    logic [FIELD_W-1:0] o_line;
    logic [FIELD_W-1:0] o_column;
    logic               o_last;

    // Stimulus and expectation stores
    t_text_item pending_bytes[$];
    t_result    expected_results[$];
    t_result    item_results[$];

    // Scanner state of the predictor
    t_mode                 scan_mode;
    logic                  in_quote;
    logic [COUNT_BITS-1:0] line_cnt;
    logic [COUNT_BITS-1:0] col_cnt;
    logic [COUNT_BITS-1:0] start_line;
    logic [COUNT_BITS-1:0] start_col;

    // Pacing and bookkeeping
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        item_taken     = 1'b0;
    int unsigned fail_count     = 0;
    int unsigned queued_total   = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned word_ends_seen = 0;
    int unsigned eoi_seen       = 0;
    int unsigned cycle_count    = 0;

    word_splitter_with_positions dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_char_value (i_char_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_out_char   (o_out_char),
        .o_line       (o_line),
        .o_column     (o_column),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Byte classes
    // ------------------------------------------------------------------------
    function automatic logic is_space_byte(input logic [7:0] c);
        case (c)
            8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C, 8'h00, 8'hFF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_punct_word(input logic [7:0] c);
        case (c)
            "[", "]", "(", ")", "<", ">", "{", "}", ",", "*", "!", "=": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Position predictor
    // ------------------------------------------------------------------------
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] v);
        logic [FIELD_W-1:0] all_ones;
        all_ones = '1;
        if (COUNT_BITS > FIELD_W && v > COUNT_BITS'(all_ones)) begin
            return all_ones;
        end
        return FIELD_W'(v);
    endfunction

    task automatic clear_scanner();
        scan_mode  = MODE_EXPECT;
        in_quote   = 1'b0;
        line_cnt   = '0;
        col_cnt    = '0;
        start_line = '0;
        start_col  = '0;
    endtask

    task automatic note_result(input logic [1:0] kind, input logic [7:0] ch,
                               input logic [COUNT_BITS-1:0] ln,
                               input logic [COUNT_BITS-1:0] col);
        t_result r;
        r.kind     = kind;
        r.out_char = ch;
        r.line     = to_field(ln);
        r.column   = to_field(col);
        r.last     = 1'b0;
        item_results.push_back(r);
    endtask

    task automatic echo_char(input logic [7:0] c);
        note_result(KIND_CHAR, c, line_cnt, col_cnt);
        col_cnt = sat_inc(col_cnt);
    endtask

    task automatic close_word();
        note_result(KIND_END, 8'h00, start_line, start_col);
    endtask

    // Handle a byte while no word is open
    task automatic scan_outside(input logic [7:0] c);
        if (c == CH_SEMI) begin
            col_cnt   = sat_inc(col_cnt);
            scan_mode = MODE_COMMENT;
        end else if (is_space_byte(c)) begin
            if (c == CH_NEWLINE) begin
                line_cnt = sat_inc(line_cnt);
                col_cnt  = '0;
            end else begin
                col_cnt = sat_inc(col_cnt);
            end
        end else begin
            start_line = line_cnt;
            start_col  = col_cnt;
            echo_char(c);
            if (c == CH_QUOTE) begin
                in_quote  = 1'b1;
                scan_mode = MODE_WORD;
            end else if (is_punct_word(c)) begin
                close_word();
                scan_mode = MODE_EXPECT;
            end else begin
                scan_mode = MODE_WORD;
            end
        end
    endtask

    // Advance the scanner by one accepted item and queue its results
    task automatic predict_item(input logic func, input logic [7:0] c);
        t_result r;
        item_results.delete();
        if (func == FUNC_EOI) begin
            if (scan_mode == MODE_WORD) begin
                close_word();
            end
            note_result(KIND_EOI, 8'h00, line_cnt, col_cnt);
            clear_scanner();
        end else begin
            case (scan_mode)
                MODE_WORD: begin
                    if (in_quote) begin
                        if (c == CH_QUOTE) begin
                            in_quote = 1'b0;
                        end
                        echo_char(c);
                    end else if (c == CH_QUOTE) begin
                        in_quote = 1'b1;
                        echo_char(c);
                    end else if (c == CH_SEMI || is_space_byte(c) || is_punct_word(c)) begin
                        close_word();
                        scan_mode = MODE_EXPECT;
                        scan_outside(c);
                    end else begin
                        echo_char(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE) begin
                        line_cnt  = sat_inc(line_cnt);
                        col_cnt   = '0;
                        scan_mode = MODE_EXPECT;
                    end else begin
                        col_cnt = sat_inc(col_cnt);
                    end
                end
                default: begin
                    scan_mode = MODE_EXPECT;
                    scan_outside(c);
                end
            endcase
        end
        foreach (item_results[i]) begin
            r      = item_results[i];
            r.last = (i == item_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_item(input logic func, input logic [7:0] c);
        t_text_item it;
        it.func = func;
        it.ch   = c;
        pending_bytes.push_back(it);
        queued_total++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_item(FUNC_TEXT, s[i]);
        end
    endtask

    function automatic logic [7:0] rand_word_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_space_byte(c) || is_punct_word(c) || c == CH_SEMI || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] rand_space_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (!is_space_byte(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_punct_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (!is_punct_word(c));
        return c;
    endfunction

    // Mostly well-formed text fragments with random content, end-of-input items, plus raw noise
    task automatic queue_random_text(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  c;
        target = queued_total + count;
        while (queued_total < target) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                len = $urandom_range(6, 1);
                repeat (len) queue_item(FUNC_TEXT, rand_word_byte());
            end else if (pick < 40) begin
                len = $urandom_range(3, 1);
                repeat (len) queue_item(FUNC_TEXT, rand_space_byte());
            end else if (pick < 52) begin
                queue_item(FUNC_TEXT, rand_punct_byte());
            end else if (pick < 64) begin
                queue_item(FUNC_TEXT, CH_QUOTE);
                len = $urandom_range(5);
                repeat (len) begin
                    do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
                    queue_item(FUNC_TEXT, c);
                end
                if ($urandom_range(9) < 8) queue_item(FUNC_TEXT, CH_QUOTE);
            end else if (pick < 74) begin
                queue_item(FUNC_TEXT, CH_SEMI);
                len = $urandom_range(5);
                repeat (len) begin
                    do c = 8'($urandom_range(255)); while (c == CH_NEWLINE);
                    queue_item(FUNC_TEXT, c);
                end
                if ($urandom_range(9) < 8) queue_item(FUNC_TEXT, CH_NEWLINE);
            end else if (pick < 80) begin
                queue_item(FUNC_EOI, 8'($urandom_range(255)));
            end else begin
                len = $urandom_range(3, 1);
                repeat (len) queue_item(FUNC_TEXT, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_sent();
        while (pending_bytes.size() != 0 || i_valid) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present items at the falling edge, hold until accepted
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_text_item next_item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!i_valid || item_taken) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item     = pending_bytes.pop_front();
                    i_valid      <= 1'b1;
                    i_func       <= next_item.func;
                    i_char_value <= next_item.ch;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results and predict accepted items at the rising edge
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            item_taken = 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d char %0d line %0d column %0d",
                           o_kind, o_out_char, o_line, o_column);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", want.kind, o_kind);
                    compare_field("out_char", want.out_char, o_out_char);
                    compare_field("line", want.line, o_line);
                    compare_field("column", want.column, o_column);
                    compare_field("last", want.last, o_last);
                    results_seen++;
                    if (want.kind == KIND_END) word_ends_seen++;
                    if (want.kind == KIND_EOI) eoi_seen++;
                end
            end
            item_taken = i_valid && o_ready;
            if (item_taken) begin
                items_accepted++;
                predict_item(i_func, i_char_value);
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed text, paced random phases
    // ------------------------------------------------------------------------
    initial begin
        clear_scanner();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: separators, one-byte words, quotes, comments, end of input
        queue_text("ab(c");
        queue_item(FUNC_TEXT, 8'hFF);
        queue_text("=\"q;\n\"z");
        queue_item(FUNC_TEXT, 8'h00);
        queue_text(";c*\n");
        queue_text("w");
        queue_item(FUNC_EOI, 8'hA5);
        queue_text("\"o");
        queue_item(FUNC_EOI, 8'h00);
        queue_text(";x");
        queue_item(FUNC_EOI, 8'hFF);
        queue_item(FUNC_EOI, 8'h5A);
        queue_text("ab;z\n!");
        queue_item(FUNC_EOI, 8'h00);

        queue_random_text(50);
        wait_sent();

        // Sender mostly idle
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        queue_random_text(50);
        wait_sent();

        // Receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        queue_random_text(50);
        wait_sent();

        // Both sides idle now and then
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        queue_random_text(55);
        queue_item(FUNC_EOI, 8'h00);
        wait_sent();

        // Drain, then watch for stray results
        recv_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results: %0d word ends, %0d end markers.",
                 items_accepted, results_seen, word_ends_seen, eoi_seen);
        $display("Covered quotes, comments, one-byte words, end of input, four pacings.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
